// ===== rtl/hsl2rgb_pkg.sv =====
// Shared constants, types and stage-load struct for the HSL to RGB converter.
// Depends on nothing; imported by hsl2rgb_channel and hsl_to_rgb_converter.
`default_nettype none

package hsl2rgb_pkg;

    localparam int FRAC_BITS = 12;
    localparam int DATA_W    = FRAC_BITS + 1;           // 0..ONE plus out-of-range inputs
    localparam int ONE       = 1 << FRAC_BITS;
    localparam int HALF      = ONE / 2;
    localparam int THIRD     = ONE / 3;
    localparam int HUE_W     = DATA_W + 2;              // signed, offset hue before wrap
    localparam int SIX_W     = FRAC_BITS + 4;           // 6x after wrap
    localparam int V_W       = FRAC_BITS + 6;           // signed hi, lo, hi - lo
    localparam int MUL_W     = 2 * DATA_W;              // l * s
    localparam int MF_W      = MUL_W - FRAC_BITS;       // (l * s) >> FRAC_BITS
    localparam int PROD_W    = V_W + DATA_W + 1;        // signed ramp product
    localparam int SUM_W     = V_W + 2;                 // signed ramp sum before clamp

    typedef enum logic [1:0] {
        SEG_RISE,
        SEG_HIGH,
        SEG_FALL,
        SEG_LOW
    } t_seg;

    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } t_stage_ld;

endpackage

`default_nettype wire

// ===== rtl/hsl2rgb_channel.sv =====
// One colour channel: hue wrap and ramp segment, ramp multiply, sum and clamp.
// Four register stages, loaded by the stage strobes from the top level; uses hsl2rgb_pkg.
`default_nettype none

module hsl2rgb_channel
    import hsl2rgb_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire t_stage_ld                i_ld,
    input  wire logic signed [HUE_W-1:0]  i_hue,
    input  wire logic signed [V_W-1:0]    i_hi,
    input  wire logic signed [V_W-1:0]    i_lo,
    input  wire logic signed [V_W-1:0]    i_diff,
    output logic             [DATA_W-1:0] o_value
);

    logic signed [HUE_W-1:0]  hue_w;
    logic        [DATA_W-1:0] hue_u;
    logic        [SIX_W-1:0]  hue6;
    t_seg                     n_seg;
    logic        [DATA_W-1:0] n_fac;

    t_seg                     r1_seg;
    logic        [DATA_W-1:0] r1_fac;
    t_seg                     r2_seg;
    logic        [DATA_W-1:0] r2_fac;
    t_seg                     r3_seg;
    logic signed [PROD_W-1:0] r3_prod;
    logic signed [V_W-1:0]    r3_hi;
    logic signed [V_W-1:0]    r3_lo;

    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [SUM_W-1:0]  ramp_sum;
    logic signed [SUM_W-1:0]  pick;
    logic        [DATA_W-1:0] n_value;
    logic        [DATA_W-1:0] r_value;

    // stage 1: wrap once, find segment and ramp factor
    always_comb begin
        hue_w = i_hue;
        if (i_hue < 0) begin
            hue_w = i_hue + HUE_W'(ONE);
        end else if (i_hue > HUE_W'(ONE)) begin
            hue_w = i_hue - HUE_W'(ONE);
        end
        hue_u = hue_w[DATA_W-1:0];
        hue6  = (SIX_W'(hue_u) << 2) + (SIX_W'(hue_u) << 1);
        priority if (hue6 < SIX_W'(ONE)) begin
            n_seg = SEG_RISE;
            n_fac = hue6[DATA_W-1:0];
        end else if (SIX_W'(hue_u) < SIX_W'(HALF)) begin
            n_seg = SEG_HIGH;
            n_fac = '0;
        end else if (hue6 < SIX_W'(4 * ONE)) begin
            n_seg = SEG_FALL;
            n_fac = DATA_W'(SIX_W'(4 * ONE) - hue6);
        end else begin
            n_seg = SEG_LOW;
            n_fac = '0;
        end
    end

    // stage 3: (hi - lo) * factor
    assign n_prod = PROD_W'(i_diff) * PROD_W'($signed({1'b0, r2_fac}));

    // stage 4: floor shift, add lo, choose by segment, clamp
    always_comb begin
        prod_sh  = r3_prod >>> FRAC_BITS;
        ramp_sum = SUM_W'(prod_sh) + SUM_W'(r3_lo);
        unique case (r3_seg)
            SEG_RISE: pick = ramp_sum;
            SEG_FALL: pick = ramp_sum;
            SEG_HIGH: pick = SUM_W'(r3_hi);
            SEG_LOW:  pick = SUM_W'(r3_lo);
            default:  pick = SUM_W'(r3_lo);
        endcase
        if (pick < 0) begin
            n_value = '0;
        end else if (pick > SUM_W'(ONE)) begin
            n_value = DATA_W'(ONE);
        end else begin
            n_value = pick[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ld.ld1) begin
            r1_seg <= n_seg;
            r1_fac <= n_fac;
        end
        if (i_ld.ld2) begin
            r2_seg <= r1_seg;
            r2_fac <= r1_fac;
        end
        if (i_ld.ld3) begin
            r3_seg  <= r2_seg;
            r3_prod <= n_prod;
            r3_hi   <= i_hi;
            r3_lo   <= i_lo;
        end
        if (i_ld.ld4) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

// ===== rtl/hsl_to_rgb_converter.sv =====
// HSL to RGB converter top level: handshake, helper values hi and lo, three channels.
// Depends on hsl2rgb_pkg and hsl2rgb_channel.
//
//   channel  direction  handshake           word
//   in       sink       i_valid / o_stall   i_hue, i_saturation, i_lightness
//   out      source     o_valid / i_stall   o_red, o_green, o_blue
//
// Four register stages: l*s multiply, hi/lo, ramp multiply, sum and clamp.
// One word per cycle while the output is not stalled; an accepted word moves through
// stages 1 to 4 in order, and o_valid shows it once it is held in stage 4.
// Synchronous active-low reset clears the stage valid bits only.
// Each stage holds while its successor is full and stalled; empty stages fill,
// so bubbles close up behind a stalled output.
`default_nettype none

module hsl_to_rgb_converter
    import hsl2rgb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic [DATA_W-1:0] i_hue,
    input  wire logic [DATA_W-1:0] i_saturation,
    input  wire logic [DATA_W-1:0] i_lightness,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic      [DATA_W-1:0] o_red,
    output logic      [DATA_W-1:0] o_green,
    output logic      [DATA_W-1:0] o_blue
);

    logic r1_v;
    logic r2_v;
    logic r3_v;
    logic r4_v;
    t_stage_ld ld;

    logic        [MUL_W-1:0]  n_mul;
    logic        [MF_W-1:0]   r1_mf;
    logic        [DATA_W-1:0] r1_l;
    logic        [DATA_W-1:0] r1_s;

    logic signed [V_W-1:0]    l_v;
    logic signed [V_W-1:0]    s_v;
    logic signed [V_W-1:0]    mf_v;
    logic signed [V_W-1:0]    n_hi;
    logic signed [V_W-1:0]    n_lo;
    logic signed [V_W-1:0]    n_diff;
    logic signed [V_W-1:0]    r2_hi;
    logic signed [V_W-1:0]    r2_lo;
    logic signed [V_W-1:0]    r2_diff;

    logic signed [HUE_W-1:0]  hue_g;
    logic signed [HUE_W-1:0]  hue_r;
    logic signed [HUE_W-1:0]  hue_b;

    always_comb begin
        ld.ld4  = !r4_v || !i_stall;
        ld.ld3  = !r3_v || ld.ld4;
        ld.ld2  = !r2_v || ld.ld3;
        ld.ld1  = !r1_v || ld.ld2;
    end

    assign o_stall = !ld.ld1;
    assign o_valid = r4_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else begin
            if (ld.ld1) r1_v <= i_valid;
            if (ld.ld2) r2_v <= r1_v;
            if (ld.ld3) r3_v <= r2_v;
            if (ld.ld4) r4_v <= r3_v;
        end
    end

    // stage 1: l * s; l * (ONE + s) >> F equals l + (l * s >> F)
    assign n_mul = MUL_W'(i_lightness) * MUL_W'(i_saturation);

    // stage 2: hi, lo and hi - lo
    always_comb begin
        l_v    = $signed(V_W'(r1_l));
        s_v    = $signed(V_W'(r1_s));
        mf_v   = $signed(V_W'(r1_mf));
        if (r1_l < DATA_W'(HALF)) begin
            n_hi = l_v + mf_v;
        end else begin
            n_hi = l_v + s_v - mf_v;
        end
        n_lo   = (l_v <<< 1) - n_hi;
        n_diff = (n_hi - l_v) <<< 1;
    end

    always_ff @(posedge i_clk) begin
        if (ld.ld1) begin
            r1_mf <= n_mul[MUL_W-1:FRAC_BITS];
            r1_l  <= i_lightness;
            r1_s  <= i_saturation;
        end
        if (ld.ld2) begin
            r2_hi   <= n_hi;
            r2_lo   <= n_lo;
            r2_diff <= n_diff;
        end
    end

    assign hue_g = $signed(HUE_W'(i_hue));
    assign hue_r = hue_g + HUE_W'(THIRD);
    assign hue_b = hue_g - HUE_W'(THIRD);

    hsl2rgb_channel u_red (
        .i_clk   (i_clk),
        .i_ld    (ld),
        .i_hue   (hue_r),
        .i_hi    (r2_hi),
        .i_lo    (r2_lo),
        .i_diff  (r2_diff),
        .o_value (o_red)
    );

    hsl2rgb_channel u_green (
        .i_clk   (i_clk),
        .i_ld    (ld),
        .i_hue   (hue_g),
        .i_hi    (r2_hi),
        .i_lo    (r2_lo),
        .i_diff  (r2_diff),
        .o_value (o_green)
    );

    hsl2rgb_channel u_blue (
        .i_clk   (i_clk),
        .i_ld    (ld),
        .i_hue   (hue_b),
        .i_hi    (r2_hi),
        .i_lo    (r2_lo),
        .i_diff  (r2_diff),
        .o_value (o_blue)
    );

endmodule

`default_nettype wire
